// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers. Each use stands on a line of its own, with no trailing semicolon.
// The enclosing module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check on every clock edge outside reset.
`define ICY_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ICY_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ICY_ASSERT(lbl, prop, msg)
`define ICY_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/icy_pkg.sv =====
package icy_pkg;

  // Framing sizes
  localparam int LEN_SCALE_DEF = 16;
  localparam int MAX_RES       = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_N_W       = $clog2(MAX_RES + 1);

  // Title key and closing mark
  localparam logic [3:0] KEY_LEN  = 4'd13;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  // Register indexes
  localparam logic REG_META_INTERVAL = 1'b0;

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_TITLE = 2'd1,
    KIND_END   = 2'd2
  } icy_kind_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_OPEN = 2'd1,
    ST_DONE = 2'd2
  } icy_status_t;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_TITLE  = 2'd1,
    PH_CLOSED = 2'd2
  } icy_phase_t;

  typedef struct packed {
    icy_kind_t   kind;
    logic [7:0]  data;
    icy_status_t status;
    logic        last;
  } icy_res_t;

  typedef struct packed {
    logic             room;
    logic [CNT_W-1:0] count;
  } icy_qstat_t;

  // Characters of StreamTitle='
  function automatic logic [7:0] key_char(input logic [3:0] p);
    logic [7:0] ch;
    case (p)
      4'd0:    ch = 8'h53; // S
      4'd1:    ch = 8'h74; // t
      4'd2:    ch = 8'h72; // r
      4'd3:    ch = 8'h65; // e
      4'd4:    ch = 8'h61; // a
      4'd5:    ch = 8'h6D; // m
      4'd6:    ch = 8'h54; // T
      4'd7:    ch = 8'h69; // i
      4'd8:    ch = 8'h74; // t
      4'd9:    ch = 8'h6C; // l
      4'd10:   ch = 8'h65; // e
      4'd11:   ch = 8'h3D; // =
      4'd12:   ch = 8'h27; // quote
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/icy_stream_if.sv =====
interface icy_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface icy_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [1:0] title_status;
  logic       last;

  modport source (output valid, output kind, output out_byte, output title_status,
                  output last, input ready);
  modport sink (input valid, input kind, input out_byte, input title_status,
                input last, output ready);
endinterface

// ===== hw/rtl/icy_core.sv =====
module icy_core #(
  parameter int LEN_SCALE = icy_pkg::LEN_SCALE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_fire,
  input  logic [7:0]                          data_byte,
  input  logic [23:0]                         meta_interval,
  input  logic                                cfg_load,
  input  logic [23:0]                         cfg_wdata,
  output icy_pkg::icy_res_t [icy_pkg::MAX_RES-1:0] res,
  output logic [icy_pkg::RES_N_W-1:0]         res_n
);

  localparam logic [11:0] SCALE = 12'(LEN_SCALE);

  logic [23:0]         audio_left_r, audio_left_nxt;
  logic [11:0]         block_left_r, block_left_nxt;
  logic [3:0]          pos_r, pos_nxt;
  icy_pkg::icy_phase_t phase_r, phase_nxt;
  logic                quote_r, quote_nxt;

  // Matcher state after this byte, before any block-end clear
  logic [3:0]          pos_m;
  icy_pkg::icy_phase_t phase_m;
  logic                quote_m;

  logic                is_meta, is_len, blk_end;

  assign is_meta = (block_left_r != 12'd0);
  assign is_len  = !is_meta && (meta_interval != 24'd0) && (audio_left_r == 24'd0);
  assign blk_end = (block_left_r == 12'd1);

  // Step the title matcher over one metadata byte
  always_comb begin
    logic [3:0] p;
    logic [3:0] pn;
    p       = 4'd0;
    pn      = 4'd0;
    pos_m   = pos_r;
    phase_m = phase_r;
    quote_m = quote_r;
    case (phase_r)
      icy_pkg::PH_SEARCH: begin
        p = (pos_r < icy_pkg::KEY_LEN) ? pos_r : 4'd0;
        if (data_byte == icy_pkg::key_char(p)) begin
          pn = p + 4'd1;
        end else begin
          // the key's first letter occurs nowhere else in it
          pn = (data_byte == icy_pkg::key_char(4'd0)) ? 4'd1 : 4'd0;
        end
        if (pn == icy_pkg::KEY_LEN) begin
          phase_m = icy_pkg::PH_TITLE;
          pn      = 4'd0;
        end
        pos_m = pn;
      end
      icy_pkg::PH_TITLE: begin
        if (quote_r && data_byte == icy_pkg::CH_SEMI) begin
          quote_m = 1'b0;
          phase_m = icy_pkg::PH_CLOSED;
        end else begin
          quote_m = (data_byte == icy_pkg::CH_QUOTE);
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    audio_left_nxt = audio_left_r;
    block_left_nxt = block_left_r;
    pos_nxt        = pos_r;
    phase_nxt      = phase_r;
    quote_nxt      = quote_r;
    if (is_meta) begin
      block_left_nxt = block_left_r - 12'd1;
      if (blk_end) begin
        pos_nxt   = 4'd0;
        phase_nxt = icy_pkg::PH_SEARCH;
        quote_nxt = 1'b0;
      end else begin
        pos_nxt   = pos_m;
        phase_nxt = phase_m;
        quote_nxt = quote_m;
      end
    end else if (is_len) begin
      block_left_nxt = {4'd0, data_byte} * SCALE;
      audio_left_nxt = meta_interval;
      pos_nxt        = 4'd0;
      phase_nxt      = icy_pkg::PH_SEARCH;
      quote_nxt      = 1'b0;
    end else if (meta_interval != 24'd0 && audio_left_r != 24'd0) begin
      audio_left_nxt = audio_left_r - 24'd1;
    end
  end

  // Results caused by this byte
  always_comb begin
    logic [icy_pkg::RES_N_W-1:0] n;
    icy_pkg::icy_status_t        st;
    n  = '0;
    st = icy_pkg::ST_NONE;
    for (int i = 0; i < icy_pkg::MAX_RES; i++) begin
      res[i] = '{kind: icy_pkg::KIND_AUDIO, data: 8'd0, status: icy_pkg::ST_NONE,
                 last: 1'b0};
    end
    if (is_meta) begin
      if (phase_r == icy_pkg::PH_TITLE) begin
        if (quote_r) begin
          if (data_byte != icy_pkg::CH_SEMI) begin
            res[n].kind = icy_pkg::KIND_TITLE;
            res[n].data = icy_pkg::CH_QUOTE;
            n = n + 1'b1;
            if (data_byte != icy_pkg::CH_QUOTE) begin
              res[n].kind = icy_pkg::KIND_TITLE;
              res[n].data = data_byte;
              n = n + 1'b1;
            end
          end
        end else if (data_byte != icy_pkg::CH_QUOTE) begin
          res[n].kind = icy_pkg::KIND_TITLE;
          res[n].data = data_byte;
          n = n + 1'b1;
        end
      end
      if (blk_end) begin
        case (phase_m)
          icy_pkg::PH_CLOSED: st = icy_pkg::ST_DONE;
          icy_pkg::PH_TITLE:  st = icy_pkg::ST_OPEN;
          default:            st = icy_pkg::ST_NONE;
        endcase
        // flush a held quote ahead of the block end
        if (phase_m == icy_pkg::PH_TITLE && quote_m) begin
          res[n].kind = icy_pkg::KIND_TITLE;
          res[n].data = icy_pkg::CH_QUOTE;
          n = n + 1'b1;
        end
        res[n].kind   = icy_pkg::KIND_END;
        res[n].status = st;
        n = n + 1'b1;
      end
    end else if (!is_len) begin
      res[n].kind = icy_pkg::KIND_AUDIO;
      res[n].data = data_byte;
      n = n + 1'b1;
    end
    if (n != '0) begin
      res[n - 1'b1].last = 1'b1;
    end
    res_n = n;
  end

  // State registers; a register write reloads the audio count with the new value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      audio_left_r <= 24'd0;
      block_left_r <= 12'd0;
      pos_r        <= 4'd0;
      phase_r      <= icy_pkg::PH_SEARCH;
      quote_r      <= 1'b0;
    end else if (cfg_load) begin
      audio_left_r <= cfg_wdata;
    end else if (in_fire) begin
      audio_left_r <= audio_left_nxt;
      block_left_r <= block_left_nxt;
      pos_r        <= pos_nxt;
      phase_r      <= phase_nxt;
      quote_r      <= quote_nxt;
    end
  end

endmodule

// ===== hw/rtl/icy_resq.sv =====
module icy_resq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic [icy_pkg::RES_N_W-1:0]         push_n,
  input  icy_pkg::icy_res_t [icy_pkg::MAX_RES-1:0] push_res,
  input  logic                                pop_ready,
  output logic                                head_valid,
  output icy_pkg::icy_res_t                   head,
  output icy_pkg::icy_qstat_t                 stat
);

  localparam int D = icy_pkg::QUEUE_DEPTH;
  localparam int W = icy_pkg::CNT_W;

  icy_pkg::icy_res_t q_r   [D];
  icy_pkg::icy_res_t q_nxt [D];
  logic [W-1:0]      count_r, count_nxt;
  logic              pop;
  logic [W-1:0]      base;
  logic [W-1:0]      add;

  assign head_valid = (count_r != '0);
  assign head       = q_r[0];
  assign pop        = head_valid && pop_ready;
  assign base       = count_r - W'(pop);
  assign add        = push ? W'(push_n) : '0;
  assign count_nxt  = base + add;

  // Room for a full burst of results from one byte
  assign stat.room  = (count_r <= W'(D - icy_pkg::MAX_RES));
  assign stat.count = count_r;

  // Shift on pop, then drop new words in behind the survivors
  always_comb begin
    logic [W-1:0] off;
    for (int i = 0; i < D; i++) begin
      off = W'(i) - base;
      if (pop && i < D - 1) begin
        q_nxt[i] = q_r[(i + 1) % D];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (W'(i) >= base && off < add) begin
        q_nxt[i] = push_res[off[icy_pkg::RES_N_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < D; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

// ===== hw/rtl/icy_metadata_deframer.sv =====
// ICY metadata deframer.
// in_ch carries one stream byte per word; out_ch carries result words: audio
// bytes, stream title bytes and a block-end word with the title status. last
// marks the final result word of each input byte. Length bytes give no word.
// meta_interval is set over the APB port (byte address 0); pready is always
// high and writes take effect at the access cycle. Write it only while idle.
// A byte accepted at a clock edge has its result words registered into a
// four-word result queue, whose head drives out_ch.
// Throughput: one byte per cycle while each byte yields at most one word and
// out_ch.ready is high; the queue drains one word per cycle, so a byte with
// two or three words (held quote, block end) slows the input. in_ch.ready is
// high while the queue holds at most one word, leaving room for a full burst.
// Reset: meta_interval is zero, so every byte passes as audio; the matcher is
// searching and the queue is empty.
// Stall: when out_ch.ready is low the head word holds, the queue fills, and
// in_ch.ready drops; no word is lost.
`include "assert_macros.svh"

module icy_metadata_deframer #(
  parameter int LEN_SCALE = icy_pkg::LEN_SCALE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  icy_in_if.sink       in_ch,
  icy_out_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [23:0]         meta_interval_r;
  logic                cfg_wr;
  logic                cfg_load;
  logic                in_fire;
  icy_pkg::icy_res_t [icy_pkg::MAX_RES-1:0] res;
  logic [icy_pkg::RES_N_W-1:0] res_n;
  icy_pkg::icy_res_t   head;
  logic                head_valid;
  icy_pkg::icy_qstat_t q_stat;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_load   = cfg_wr && (cfg_paddr[2] == icy_pkg::REG_META_INTERVAL);

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[2] == icy_pkg::REG_META_INTERVAL) begin
      cfg_prdata = {8'd0, meta_interval_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_interval_r <= 24'd0;
    end else if (cfg_load) begin
      meta_interval_r <= cfg_pwdata[23:0];
    end
  end

  // Input handshake
  assign in_ch.ready = q_stat.room;
  assign in_fire     = in_ch.valid && in_ch.ready;

  icy_core #(
    .LEN_SCALE (LEN_SCALE)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .data_byte     (in_ch.data_byte),
    .meta_interval (meta_interval_r),
    .cfg_load      (cfg_load),
    .cfg_wdata     (cfg_pwdata[23:0]),
    .res           (res),
    .res_n         (res_n)
  );

  icy_resq u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_n     (res_n),
    .push_res   (res),
    .pop_ready  (out_ch.ready),
    .head_valid (head_valid),
    .head       (head),
    .stat       (q_stat)
  );

  // Result channel
  assign out_ch.valid        = head_valid;
  assign out_ch.kind         = head.kind;
  assign out_ch.out_byte     = head.data;
  assign out_ch.title_status = head.status;
  assign out_ch.last         = head.last;

  `ICY_ASSERT(a_q_bound, q_stat.count <= icy_pkg::CNT_W'(icy_pkg::QUEUE_DEPTH), "result queue overflow")
  `ICY_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_ch.valid, "result word right after reset")
  `ICY_ASSERT(a_end_last, out_ch.valid && out_ch.kind == icy_pkg::KIND_END |-> out_ch.last, "block end word not last")
  `ICY_ASSERT(a_status_end, out_ch.valid && out_ch.kind != icy_pkg::KIND_END |-> out_ch.title_status == icy_pkg::ST_NONE, "status on a data word")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 90;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 220;

  localparam logic [8*13-1:0] TITLE_KEY = "StreamTitle='";

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_op_t;

  typedef struct packed {
    row_op_t           op;
    logic [23:0]       value;
    logic              typed;
    icy_pkg::icy_res_t word;
  } row_t;

  localparam icy_pkg::icy_res_t NO_WORD = '0;
  localparam int DIR_ROWS = 25;

  // Directed stream: pass-through after reset, framing at interval 2 with a
  // zero length byte, then one 16-byte block holding a complete title
  localparam row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_BYTE, 24'h00, 1'b1, '{icy_pkg::KIND_AUDIO, 8'h00, icy_pkg::ST_NONE, 1'b1}},
    '{ROW_BYTE, 24'hFF, 1'b1, '{icy_pkg::KIND_AUDIO, 8'hFF, icy_pkg::ST_NONE, 1'b1}},
    '{ROW_WRITE, 24'd2, 1'b0, NO_WORD},
    '{ROW_BYTE, 24'h55, 1'b1, '{icy_pkg::KIND_AUDIO, 8'h55, icy_pkg::ST_NONE, 1'b1}},
    '{ROW_BYTE, 24'hAA, 1'b1, '{icy_pkg::KIND_AUDIO, 8'hAA, icy_pkg::ST_NONE, 1'b1}},
    '{ROW_BYTE, 24'h00, 1'b0, NO_WORD},
    '{ROW_BYTE, 24'h3C, 1'b1, '{icy_pkg::KIND_AUDIO, 8'h3C, icy_pkg::ST_NONE, 1'b1}},
    '{ROW_BYTE, 24'hC3, 1'b1, '{icy_pkg::KIND_AUDIO, 8'hC3, icy_pkg::ST_NONE, 1'b1}},
    '{ROW_BYTE, 24'h01, 1'b0, NO_WORD},
    '{ROW_BYTE, "S", 1'b0, NO_WORD}, '{ROW_BYTE, "t", 1'b0, NO_WORD},
    '{ROW_BYTE, "r", 1'b0, NO_WORD}, '{ROW_BYTE, "e", 1'b0, NO_WORD},
    '{ROW_BYTE, "a", 1'b0, NO_WORD}, '{ROW_BYTE, "m", 1'b0, NO_WORD},
    '{ROW_BYTE, "T", 1'b0, NO_WORD}, '{ROW_BYTE, "i", 1'b0, NO_WORD},
    '{ROW_BYTE, "t", 1'b0, NO_WORD}, '{ROW_BYTE, "l", 1'b0, NO_WORD},
    '{ROW_BYTE, "e", 1'b0, NO_WORD}, '{ROW_BYTE, "=", 1'b0, NO_WORD},
    '{ROW_BYTE, "'", 1'b0, NO_WORD}, '{ROW_BYTE, "x", 1'b0, NO_WORD},
    '{ROW_BYTE, "'", 1'b0, NO_WORD}, '{ROW_BYTE, ";", 1'b0, NO_WORD}
  };

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  icy_in_if  in_ch ();
  icy_out_if out_ch ();

  icy_metadata_deframer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Deframer state as predicted
  logic [23:0]         interval_cfg = '0;
  logic [23:0]         audio_due    = '0;
  logic [11:0]         meta_due     = '0;
  logic [3:0]          key_pos      = '0;
  icy_pkg::icy_phase_t title_ph     = icy_pkg::PH_SEARCH;
  logic                quote_wait   = 1'b0;

  icy_pkg::icy_res_t step_words [$];
  icy_pkg::icy_res_t words_due [$];
  icy_pkg::icy_res_t head_word;
  logic [7:0]        pending [$];

  int errors        = 0;
  int random_sent   = 0;
  int feed_gap_pct  = 0;
  int drain_gap_pct = 0;
  int holds_asked   = 0;
  int holds_granted = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] key_at(input logic [3:0] p);
    return TITLE_KEY[8*(12-p) +: 8];
  endfunction

  function automatic void add_word(input icy_pkg::icy_kind_t k, input logic [7:0] b,
                                   input icy_pkg::icy_status_t s);
    icy_pkg::icy_res_t w;
    w.kind   = k;
    w.data   = b;
    w.status = s;
    w.last   = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void reset_matcher();
    key_pos    = '0;
    title_ph   = icy_pkg::PH_SEARCH;
    quote_wait = 1'b0;
  endfunction

  // Track the title key and emit title bytes, holding a quote back one byte
  function automatic void title_scan(input logic [7:0] c);
    logic [3:0] p;
    if (title_ph == icy_pkg::PH_SEARCH) begin
      p = (key_pos < icy_pkg::KEY_LEN) ? key_pos : 4'd0;
      if (c == key_at(p)) p = p + 4'd1;
      else p = (c == key_at(4'd0)) ? 4'd1 : 4'd0;
      if (p == icy_pkg::KEY_LEN) begin
        title_ph = icy_pkg::PH_TITLE;
        p = 4'd0;
      end
      key_pos = p;
    end else if (title_ph == icy_pkg::PH_TITLE) begin
      if (quote_wait) begin
        if (c == icy_pkg::CH_SEMI) begin
          quote_wait = 1'b0;
          title_ph = icy_pkg::PH_CLOSED;
        end else begin
          add_word(icy_pkg::KIND_TITLE, icy_pkg::CH_QUOTE, icy_pkg::ST_NONE);
          quote_wait = (c == icy_pkg::CH_QUOTE);
          if (c != icy_pkg::CH_QUOTE) add_word(icy_pkg::KIND_TITLE, c, icy_pkg::ST_NONE);
        end
      end else if (c == icy_pkg::CH_QUOTE) begin
        quote_wait = 1'b1;
      end else begin
        add_word(icy_pkg::KIND_TITLE, c, icy_pkg::ST_NONE);
      end
    end
  endfunction

  // Work out the words one accepted stream byte yields
  function automatic void deframe_byte(input logic [7:0] c);
    icy_pkg::icy_status_t st;
    step_words.delete();
    if (meta_due != 0) begin
      title_scan(c);
      meta_due = meta_due - 12'd1;
      if (meta_due == 0) begin
        if (title_ph == icy_pkg::PH_CLOSED) begin
          st = icy_pkg::ST_DONE;
        end else if (title_ph == icy_pkg::PH_TITLE) begin
          if (quote_wait) add_word(icy_pkg::KIND_TITLE, icy_pkg::CH_QUOTE, icy_pkg::ST_NONE);
          st = icy_pkg::ST_OPEN;
        end else begin
          st = icy_pkg::ST_NONE;
        end
        add_word(icy_pkg::KIND_END, 8'h00, st);
        reset_matcher();
      end
    end else if (interval_cfg != 0 && audio_due == 0) begin
      meta_due = 12'(c * icy_pkg::LEN_SCALE_DEF);
      audio_due = interval_cfg;
      reset_matcher();
    end else begin
      add_word(icy_pkg::KIND_AUDIO, c, icy_pkg::ST_NONE);
      if (interval_cfg != 0 && audio_due != 0) audio_due = audio_due - 24'd1;
    end
    if (step_words.size() != 0) step_words[step_words.size()-1].last = 1'b1;
  endfunction

  // Pick gap rates from how far the random stream has got
  function automatic void set_idle();
    if (random_sent < 90) begin
      feed_gap_pct = 22;
      drain_gap_pct = 69;
    end else if (random_sent < 180) begin
      feed_gap_pct = 69;
      drain_gap_pct = 22;
    end else begin
      feed_gap_pct = 0;
      drain_gap_pct = 0;
    end
  endfunction

  // Offer one byte, wait for the handshake, then queue its expected words
  task automatic send_byte(input logic [7:0] b, input bit use_typed,
                           input icy_pkg::icy_res_t typed_word);
    while ($urandom_range(0, 99) < feed_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    deframe_byte(b);
    if (use_typed) words_due.push_back(typed_word);
    else foreach (step_words[i]) words_due.push_back(step_words[i]);
  endtask

  // Drop valid and let every expected word drain before touching the register
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write meta_interval, then read it back
  task automatic write_interval(input logic [23:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {icy_pkg::REG_META_INTERVAL, 2'b00};
    cfg_pwdata <= {8'h00, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {8'h00, val}) begin
      $error("meta_interval: expected %0h, got %0h", val, cfg_prdata);
      errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    interval_cfg = val;
    audio_due = val;
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) pending.push_back(s[i]);
  endfunction

  function automatic void push_key();
    for (int i = 0; i < 13; i++) pending.push_back(key_at(4'(i)));
  endfunction

  function automatic logic [7:0] title_char(input bit allow_quote);
    logic [7:0] ch;
    case ($urandom_range(0, 9))
      0:       ch = 8'($urandom_range(0, 255));
      1:       ch = icy_pkg::CH_QUOTE;
      2:       ch = icy_pkg::CH_SEMI;
      3:       ch = 8'h20;
      default: ch = 8'(8'h61 + $urandom_range(0, 25));
    endcase
    if (!allow_quote && ch == icy_pkg::CH_QUOTE) ch = 8'h71;
    return ch;
  endfunction

  // Build one metadata block: no key, broken key, complete or open title,
  // second key after the close, or an open title ending on a quote
  function automatic void make_block(input int len);
    int start;
    int mode;
    start = pending.size();
    mode = $urandom_range(0, 9);
    repeat ($urandom_range(0, 2)) pending.push_back(8'(8'h61 + $urandom_range(0, 25)));
    if (mode == 0) push_text("StreamTi-");
    if (mode == 2) pending.push_back(key_at(4'd0));
    if (mode != 1) push_key();
    repeat ($urandom_range(0, 6)) pending.push_back(title_char(mode < 8));
    if (mode <= 6) push_text("';");
    if (mode == 3) begin
      push_key();
      push_text("zz';");
    end
    while (pending.size() - start < len)
      pending.push_back(mode >= 8 ? title_char(1'b0) : 8'($urandom_range(0, 255)));
    while (pending.size() - start > len) pending.delete(pending.size() - 1);
    if (mode >= 8) pending[pending.size()-1] = icy_pkg::CH_QUOTE;
  endfunction

  function automatic logic [7:0] pick_len();
    logic [7:0] l;
    case ($urandom_range(0, 9))
      0:       l = 8'd0;
      1:       l = 8'd1;
      2:       l = 8'd3;
      default: l = 8'd2;
    endcase
    return l;
  endfunction

  function automatic void make_frame(input int mi, input logic [7:0] len_byte);
    repeat (mi) pending.push_back(8'($urandom_range(0, 255)));
    pending.push_back(len_byte);
    if (len_byte != 0) make_block(int'(len_byte) * icy_pkg::LEN_SCALE_DEF);
  endfunction

  task automatic feed_pending();
    while (pending.size() != 0) begin
      set_idle();
      if (random_sent == 180) holds_asked++;
      send_byte(pending.pop_front(), 1'b0, NO_WORD);
      random_sent++;
    end
  endtask

  // One setting of meta_interval and the stream that follows it
  task automatic run_phase(input logic [23:0] mi, input int nframes);
    int cut;
    wait_drained();
    write_interval(mi);
    // finish a block left open by the previous phase
    repeat (meta_due) pending.push_back(8'($urandom_range(0, 255)));
    if (mi == 0 || mi > 64) begin
      if ($urandom_range(0, 1) == 1) push_key();
      repeat (20) pending.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (nframes) make_frame(int'(mi), pick_len());
      // leave the next frame unfinished now and then
      if ($urandom_range(0, 2) == 0) begin
        cut = pending.size();
        make_frame(int'(mi), 8'd2);
        repeat ($urandom_range(1, pending.size() - cut - 1))
          pending.delete(pending.size() - 1);
      end
    end
    feed_pending();
  endtask

  // Result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (holds_granted != holds_asked) begin
      holds_granted = holds_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= drain_gap_pct);
    end
  end

  // Check each accepted word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (words_due.size() == 0) begin
        $error("unexpected word: kind %0d, out_byte %0h", out_ch.kind, out_ch.out_byte);
        errors++;
      end else begin
        head_word = words_due.pop_front();
        if (out_ch.kind !== head_word.kind) begin
          $error("kind: expected %0d, got %0d", head_word.kind, out_ch.kind);
          errors++;
        end
        if (out_ch.out_byte !== head_word.data) begin
          $error("out_byte: expected %0h, got %0h", head_word.data, out_ch.out_byte);
          errors++;
        end
        if (out_ch.title_status !== head_word.status) begin
          $error("title_status: expected %0d, got %0d", head_word.status,
                 out_ch.title_status);
          errors++;
        end
        if (out_ch.last !== head_word.last) begin
          $error("last: expected %0b, got %0b", head_word.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("icy_metadata_deframer test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int phase_no;
    logic [23:0] mi;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= 8'h00;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows
    set_idle();
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].op == ROW_WRITE) begin
        wait_drained();
        write_interval(DIRECTED[r].value);
      end else begin
        send_byte(DIRECTED[r].value[7:0], DIRECTED[r].typed, DIRECTED[r].word);
      end
    end

    // Random phases over several intervals, extremes included
    phase_no = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase_no % 6)
        0:       mi = 24'd1;
        1:       mi = 24'd0;
        2:       mi = 24'($urandom_range(2, 6));
        3:       mi = 24'hFFFFFF;
        4:       mi = 24'($urandom_range(1, 12));
        default: mi = 24'd2;
      endcase
      run_phase(mi, $urandom_range(2, 3));
      phase_no++;
    end

    wait_drained();
    if (errors == 0) begin
      $display("icy_metadata_deframer test passed");
    end else begin
      $display("icy_metadata_deframer test failed");
    end
    $finish;
  end

endmodule
